// File: rtl/tod_pkg.sv
// tod_pkg: types, action codes and constants for the time-of-day arithmetic unit
// used by every module under rtl; depends on nothing

package tod_pkg;

   // action codes; codes above compare behave as validate
   localparam logic [2:0] ACT_VALIDATE = 3'd0;
   localparam logic [2:0] ACT_ADD      = 3'd1;
   localparam logic [2:0] ACT_SUB      = 3'd2;
   localparam logic [2:0] ACT_DURATION = 3'd3;
   localparam logic [2:0] ACT_COMPARE  = 3'd4;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;
   localparam logic [4:0]  MAX_HOUR      = 5'd23;
   localparam logic [5:0]  MAX_MINSEC    = 6'd59;

   // 86400 = 128 * 675; floor(2^32 / 675) underestimates the quotient by at most one
   localparam logic [10:0] OFF_DIV   = 11'd675;
   localparam logic [22:0] OFF_RECIP = 23'd6362914;
   // ceil(2^20 / 225) is exact for (seconds >> 4) below 5400
   localparam logic [12:0] HOUR_RECIP = 13'd4661;
   // ceil(2^14 / 15) is exact for (remainder >> 2) below 900
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   typedef struct packed {
      logic [2:0] action;
      logic       a_valid;
      logic       times_equal;
      logic       a_before_b;
      logic       a_after_b;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [16:0] ta;
      logic [16:0] tb;
      logic [6:0]  off_lo;
      logic [23:0] off_x;
      logic [46:0] off_prod;
   } front_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [16:0] ta_d;
      logic [16:0] tb_d;
      logic [16:0] off_d;
   } reduce_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [16:0] shifted;
      logic [16:0] duration;
   } shift_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [16:0] duration;
   } result_type;

endpackage

// File: rtl/tod_front.sv
// tod_front: first stage, second counts of A and B, validity, compare flags
// and the reciprocal product for the offset reduction; depends on tod_pkg

module tod_front (
   input  logic                  clock,
   input  logic                  load,
   input  logic [2:0]            action,
   input  logic [4:0]            hour_a,
   input  logic [5:0]            minute_a,
   input  logic [5:0]            second_a,
   input  logic [4:0]            hour_b,
   input  logic [5:0]            minute_b,
   input  logic [5:0]            second_b,
   input  logic [30:0]           offset_seconds,
   output tod_pkg::front_type    front_o
);
   import tod_pkg::*;

   front_type s1_in;
   front_type s1_ff;
   logic      is_cmp;

   always_comb begin
      s1_in.ta = 17'(hour_a) * SECS_PER_HOUR + 17'(minute_a) * SECS_PER_MIN
                 + 17'(second_a);
      s1_in.tb = 17'(hour_b) * SECS_PER_HOUR + 17'(minute_b) * SECS_PER_MIN
                 + 17'(second_b);
      is_cmp = (action == ACT_COMPARE);
      s1_in.ctl.action      = action;
      s1_in.ctl.a_valid     = (hour_a <= MAX_HOUR) && (minute_a <= MAX_MINSEC)
                              && (second_a <= MAX_MINSEC);
      s1_in.ctl.times_equal = is_cmp && (hour_a == hour_b) && (minute_a == minute_b)
                              && (second_a == second_b);
      s1_in.ctl.a_before_b  = is_cmp && (s1_in.ta < s1_in.tb);
      s1_in.ctl.a_after_b   = is_cmp && (s1_in.ta > s1_in.tb);
      // low seven bits pass through, the rest is reduced modulo 675
      s1_in.off_lo   = offset_seconds[6:0];
      s1_in.off_x    = offset_seconds[30:7];
      s1_in.off_prod = 47'(s1_in.off_x) * 47'(OFF_RECIP);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

   assign front_o = s1_ff;

endmodule

// File: rtl/tod_reduce.sv
// tod_reduce: second stage, brings offset and both second counts into one day
// depends on tod_pkg

module tod_reduce (
   input  logic                  clock,
   input  logic                  load,
   input  tod_pkg::front_type    front_i,
   output tod_pkg::reduce_type   reduce_o
);
   import tod_pkg::*;

   reduce_type  s2_in;
   reduce_type  s2_ff;
   logic [14:0] quot;
   logic [23:0] quot_mul;
   logic [23:0] rem_raw;
   logic [10:0] rem_est;
   logic [9:0]  rem;

   always_comb begin
      quot     = front_i.off_prod[46:32];
      quot_mul = 24'(quot) * 24'(OFF_DIV);
      rem_raw  = front_i.off_x - quot_mul;
      rem_est  = rem_raw[10:0];
      // estimate may be one short
      if (rem_est >= OFF_DIV) begin
         rem = 10'(rem_est - OFF_DIV);
      end else begin
         rem = rem_est[9:0];
      end
      s2_in.ctl   = front_i.ctl;
      s2_in.off_d = {rem, front_i.off_lo};
      s2_in.ta_d  = (front_i.ta >= SECS_PER_DAY) ? front_i.ta - SECS_PER_DAY : front_i.ta;
      s2_in.tb_d  = (front_i.tb >= SECS_PER_DAY) ? front_i.tb - SECS_PER_DAY : front_i.tb;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_ff <= s2_in;
      end
   end

   assign reduce_o = s2_ff;

endmodule

// File: rtl/tod_shift.sv
// tod_shift: third stage, shifted time for add and subtract and the forward
// duration, each wrapped modulo one day; depends on tod_pkg

module tod_shift (
   input  logic                  clock,
   input  logic                  load,
   input  tod_pkg::reduce_type   reduce_i,
   output tod_pkg::shift_type    shift_o
);
   import tod_pkg::*;

   localparam logic [17:0] DAY_WIDE = 18'(SECS_PER_DAY);

   shift_type   s3_in;
   shift_type   s3_ff;
   logic [17:0] sum_raw;
   logic [17:0] diff_raw;
   logic [17:0] dur_raw;
   logic [17:0] sum_mod;
   logic [17:0] diff_mod;
   logic [17:0] dur_mod;

   always_comb begin
      sum_raw  = 18'(reduce_i.ta_d) + 18'(reduce_i.off_d);
      diff_raw = 18'(reduce_i.ta_d) + DAY_WIDE - 18'(reduce_i.off_d);
      dur_raw  = 18'(reduce_i.tb_d) + DAY_WIDE - 18'(reduce_i.ta_d);
      sum_mod  = (sum_raw >= DAY_WIDE) ? sum_raw - DAY_WIDE : sum_raw;
      diff_mod = (diff_raw >= DAY_WIDE) ? diff_raw - DAY_WIDE : diff_raw;
      dur_mod  = (dur_raw >= DAY_WIDE) ? dur_raw - DAY_WIDE : dur_raw;

      s3_in.ctl = reduce_i.ctl;
      unique case (reduce_i.ctl.action)
         ACT_ADD: begin
            s3_in.shifted = sum_mod[16:0];
         end
         ACT_SUB: begin
            s3_in.shifted = diff_mod[16:0];
         end
         default: begin
            s3_in.shifted = '0;
         end
      endcase
      s3_in.duration = (reduce_i.ctl.action == ACT_DURATION) ? dur_mod[16:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s3_ff <= s3_in;
      end
   end

   assign shift_o = s3_ff;

endmodule

// File: rtl/tod_split.sv
// tod_split: fourth and fifth stages, split a second count into hour, then
// minute and second, by reciprocal multiplies; depends on tod_pkg

module tod_split (
   input  logic                  clock,
   input  logic                  load_hour,
   input  logic                  load_out,
   input  tod_pkg::shift_type    shift_i,
   output tod_pkg::result_type   result_o
);
   import tod_pkg::*;

   typedef struct packed {
      tod_pkg::ctl_type ctl;
      logic [4:0]       hour;
      logic [11:0]      rem;
      logic [16:0]      duration;
   } hour_type;

   hour_type    s4_in;
   hour_type    s4_ff;
   result_type  s5_in;
   result_type  s5_ff;
   logic [25:0] hour_prod;
   logic [16:0] hour_secs;
   logic [16:0] rem_wide;
   logic [19:0] min_prod;
   logic [11:0] min_secs;
   logic [11:0] sec_wide;

   always_comb begin
      hour_prod      = 26'(shift_i.shifted[16:4]) * 26'(HOUR_RECIP);
      s4_in.hour     = hour_prod[24:20];
      hour_secs      = 17'(s4_in.hour) * SECS_PER_HOUR;
      rem_wide       = shift_i.shifted - hour_secs;
      s4_in.rem      = rem_wide[11:0];
      s4_in.ctl      = shift_i.ctl;
      s4_in.duration = shift_i.duration;
   end

   always_ff @(posedge clock) begin
      if (load_hour) begin
         s4_ff <= s4_in;
      end
   end

   always_comb begin
      min_prod       = 20'(s4_ff.rem[11:2]) * 20'(MIN_RECIP);
      s5_in.minute   = min_prod[19:14];
      min_secs       = 12'(s5_in.minute) * 12'(SECS_PER_MIN);
      sec_wide       = s4_ff.rem - min_secs;
      s5_in.second   = sec_wide[5:0];
      s5_in.hour     = s4_ff.hour;
      s5_in.ctl      = s4_ff.ctl;
      s5_in.duration = s4_ff.duration;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         s5_ff <= s5_in;
      end
   end

   assign result_o = s5_ff;

endmodule

// File: rtl/time_of_day_arithmetic_unit_top.sv
// time_of_day_arithmetic_unit_top: five-stage time-of-day arithmetic pipeline
// depends on tod_pkg, tod_front, tod_reduce, tod_shift, tod_split
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | action, times A and B, offset
//   rsp     | out       | rsp_valid/rsp_stall  | shifted time, duration, flags
//
// one transaction per cycle sustained unless the response stalls; results pass
// front, reduce, shift, hour and minute stages, the depth set by the offset
// modulo reduction and the hour and minute reciprocal multiplies
// reset clears only the stage valid bits
// a stage holds while its successor is full and held; empty stages keep filling,
// so requests are taken under a stalled response until all five stages are full

module time_of_day_arithmetic_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_hour_a,
   input  logic [5:0]  req_minute_a,
   input  logic [5:0]  req_second_a,
   input  logic [4:0]  req_hour_b,
   input  logic [5:0]  req_minute_b,
   input  logic [5:0]  req_second_b,
   input  logic [30:0] req_offset_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [16:0] rsp_duration_out,
   output logic        rsp_a_valid,
   output logic        rsp_times_equal,
   output logic        rsp_a_before_b,
   output logic        rsp_a_after_b
);
   import tod_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] ready;
   front_type         front;
   reduce_type        reduce;
   shift_type         shift;
   result_type        result;

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         if (ready[i]) begin
            valid_in[i] = valid_ff[i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];

   tod_front u_front (
      .clock          (clock),
      .load           (ready[0]),
      .action         (req_action),
      .hour_a         (req_hour_a),
      .minute_a       (req_minute_a),
      .second_a       (req_second_a),
      .hour_b         (req_hour_b),
      .minute_b       (req_minute_b),
      .second_b       (req_second_b),
      .offset_seconds (req_offset_seconds),
      .front_o        (front)
   );

   tod_reduce u_reduce (
      .clock    (clock),
      .load     (ready[1]),
      .front_i  (front),
      .reduce_o (reduce)
   );

   tod_shift u_shift (
      .clock    (clock),
      .load     (ready[2]),
      .reduce_i (reduce),
      .shift_o  (shift)
   );

   tod_split u_split (
      .clock     (clock),
      .load_hour (ready[3]),
      .load_out  (ready[4]),
      .shift_i   (shift),
      .result_o  (result)
   );

   assign rsp_valid        = valid_ff[STAGES-1];
   assign rsp_hour_out     = result.hour;
   assign rsp_minute_out   = result.minute;
   assign rsp_second_out   = result.second;
   assign rsp_duration_out = result.duration;
   assign rsp_a_valid      = result.ctl.a_valid;
   assign rsp_times_equal  = result.ctl.times_equal;
   assign rsp_a_before_b   = result.ctl.a_before_b;
   assign rsp_a_after_b    = result.ctl.a_after_b;

`ifndef SYNTHESIS
   // input is held off only when every stage is full and the response is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("request stalled with a free stage");

   // equal, before and after exclude each other
   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_times_equal, rsp_a_before_b, rsp_a_after_b}))
      else $error("compare flags not exclusive");

   // shifted time and duration always lie within a day
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour_out <= MAX_HOUR && rsp_minute_out <= MAX_MINSEC
                     && rsp_second_out <= MAX_MINSEC
                     && rsp_duration_out < SECS_PER_DAY))
      else $error("result outside one day");

   // a duration result carries no shifted time and no compare flags
   a_action_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_duration_out != '0) |->
         (rsp_hour_out == '0 && rsp_minute_out == '0 && rsp_second_out == '0
          && !rsp_times_equal && !rsp_a_before_b && !rsp_a_after_b))
      else $error("fields of different actions mixed");
`endif

endmodule
